>>> src/s5rp_pkg.sv
// Package for the SOCKS5 request parser: phase encoding, result kinds,
// address type codes and the request and result structures.
// No dependencies.
`default_nettype none

package s5rp_pkg;

    typedef enum logic [3:0] {
        PH_VERSION  = 4'd0,
        PH_COMMAND  = 4'd1,
        PH_RESERVED = 4'd2,
        PH_TYPE     = 4'd3,
        PH_IPV4     = 4'd4,
        PH_LENGTH   = 4'd5,
        PH_NAME     = 4'd6,
        PH_PORT_HI  = 4'd7,
        PH_PORT_LO  = 4'd8
    } phase_t;

    localparam logic [1:0] KIND_NAME     = 2'd0;
    localparam logic [1:0] KIND_DONE     = 2'd1;
    localparam logic [1:0] KIND_BAD_TYPE = 2'd2;

    localparam logic [7:0] TYPE_IPV4   = 8'd1;
    localparam logic [7:0] TYPE_DOMAIN = 8'd3;

    // Count value of the last IPv4 address byte.
    localparam logic [7:0] IPV4_LAST = 8'd3;

    typedef struct packed {
        logic       abort;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  version;
        logic [7:0]  command;
        logic [7:0]  address_type;
        logic [31:0] ipv4_address;
        logic [7:0]  domain_length;
        logic [7:0]  name_byte;
        logic [15:0] port;
    } result_t;

endpackage

`default_nettype wire

>>> src/s5rp_in_stage.sv
// Input register of the SOCKS5 request parser: holds one accepted request byte
// until the parser stage takes it. Depends on s5rp_pkg.
`default_nettype none

module s5rp_in_stage (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire s5rp_pkg::in_item_t in_item,
    input  wire                  take,
    output logic                 held_valid,
    output s5rp_pkg::in_item_t   held_item
);
    import s5rp_pkg::*;

    logic     valid_reg, valid_next;
    in_item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

>>> src/s5rp_parser.sv
// Parser stage of the SOCKS5 request parser: phase state machine, held request
// fields, and the result, if any, for each byte. Depends on s5rp_pkg.
`default_nettype none

module s5rp_parser (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  advance,
    input  wire s5rp_pkg::in_item_t item,
    output logic                 res_valid,
    output s5rp_pkg::result_t    res
);
    import s5rp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  version_reg, version_next;
    logic [7:0]  command_reg, command_next;
    logic [7:0]  type_reg, type_next;
    logic [31:0] address_reg, address_next;
    logic [7:0]  length_reg, length_next;
    logic [15:0] port_reg, port_next;

    logic [7:0] b;
    logic [7:0] count_inc;

    assign b         = item.data_byte;
    assign count_inc = count_reg + 8'd1;

    // Next state and held fields.
    always_comb begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        version_next = version_reg;
        command_next = command_reg;
        type_next    = type_reg;
        address_next = address_reg;
        length_next  = length_reg;
        port_next    = port_reg;
        if (item.abort) begin
            phase_next   = PH_VERSION;
            count_next   = '0;
            version_next = '0;
            command_next = '0;
            type_next    = '0;
            address_next = '0;
            length_next  = '0;
            port_next    = '0;
        end else begin
            case (phase_reg)
                PH_COMMAND: begin
                    command_next = b;
                    phase_next   = PH_RESERVED;
                end
                PH_RESERVED: begin
                    phase_next = PH_TYPE;
                end
                PH_TYPE: begin
                    type_next    = b;
                    address_next = '0;
                    length_next  = '0;
                    port_next    = '0;
                    count_next   = '0;
                    if (b == TYPE_IPV4) begin
                        phase_next = PH_IPV4;
                    end else if (b == TYPE_DOMAIN) begin
                        phase_next = PH_LENGTH;
                    end else begin
                        phase_next = PH_VERSION;
                    end
                end
                PH_IPV4: begin
                    address_next = {address_reg[23:0], b};
                    if (count_reg >= IPV4_LAST) begin
                        count_next = '0;
                        phase_next = PH_PORT_HI;
                    end else begin
                        count_next = count_inc;
                    end
                end
                PH_LENGTH: begin
                    length_next = b;
                    count_next  = '0;
                    phase_next  = (b == 8'd0) ? PH_PORT_HI : PH_NAME;
                end
                PH_NAME: begin
                    if (count_inc >= length_reg) begin
                        count_next = '0;
                        phase_next = PH_PORT_HI;
                    end else begin
                        count_next = count_inc;
                    end
                end
                PH_PORT_HI: begin
                    port_next  = {b, 8'd0};
                    phase_next = PH_PORT_LO;
                end
                PH_PORT_LO: begin
                    port_next  = {port_reg[15:8], b};
                    phase_next = PH_VERSION;
                end
                default: begin
                    // Unused phase codes behave like the version phase.
                    version_next = b;
                    command_next = '0;
                    type_next    = '0;
                    address_next = '0;
                    length_next  = '0;
                    port_next    = '0;
                    count_next   = '0;
                    phase_next   = PH_COMMAND;
                end
            endcase
        end
    end

    // Result for the current byte.
    always_comb begin
        res_valid         = 1'b0;
        res.kind          = KIND_NAME;
        res.version       = version_reg;
        res.command       = command_reg;
        res.address_type  = type_reg;
        res.ipv4_address  = '0;
        res.domain_length = '0;
        res.name_byte     = '0;
        res.port          = '0;
        if (!item.abort) begin
            case (phase_reg)
                PH_TYPE: begin
                    res.address_type = b;
                    if (b != TYPE_IPV4 && b != TYPE_DOMAIN) begin
                        res_valid = 1'b1;
                        res.kind  = KIND_BAD_TYPE;
                    end
                end
                PH_NAME: begin
                    res_valid         = 1'b1;
                    res.kind          = KIND_NAME;
                    res.domain_length = length_reg;
                    res.name_byte     = b;
                end
                PH_PORT_LO: begin
                    res_valid         = 1'b1;
                    res.kind          = KIND_DONE;
                    res.ipv4_address  = address_reg;
                    res.domain_length = length_reg;
                    res.port          = {port_reg[15:8], b};
                end
                default: begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_VERSION;
            count_reg   <= '0;
            version_reg <= '0;
            command_reg <= '0;
            type_reg    <= '0;
            address_reg <= '0;
            length_reg  <= '0;
            port_reg    <= '0;
        end else if (advance) begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            version_reg <= version_next;
            command_reg <= command_next;
            type_reg    <= type_next;
            address_reg <= address_next;
            length_reg  <= length_next;
            port_reg    <= port_next;
        end
    end

endmodule

`default_nettype wire

>>> src/s5rp_out_reg.sv
// Result register of the SOCKS5 request parser: holds one result until the
// downstream side takes it. Depends on s5rp_pkg.
`default_nettype none

module s5rp_out_reg (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 load,
    input  wire s5rp_pkg::result_t load_res,
    output logic                free,
    output logic                out_valid,
    input  wire                 out_ready,
    output s5rp_pkg::result_t   out_res
);
    import s5rp_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= load_res;
        end
    end

endmodule

`default_nettype wire

>>> src/socks5_request_parser.sv
// SOCKS5 request parser, one request byte per transfer.
// A byte is registered in the input register and its result then in the result
// register, from which it can be taken downstream.
// Throughput: one byte per cycle while the output is taken; the input register, the
// parser stage and the result register each move one byte per cycle.
// Reset (aresetn low, synchronous) empties both registers and returns the parser
// to waiting for a version byte with all held fields cleared.
`default_nettype none

module socks5_request_parser (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] data_byte
    input  wire         s_tuser,   // [0] abort
    output logic        m_tvalid,
    input  wire         m_tready,
    // [7:0] version, [15:8] command, [23:16] address_type,
    // [55:24] ipv4_address, [63:56] domain_length, [71:64] name_byte, [87:72] port
    output logic [87:0] m_tdata,
    output logic [1:0]  m_tuser    // [1:0] kind
);
    import s5rp_pkg::*;

    in_item_t in_item;
    in_item_t held_item;
    logic     held_valid;
    logic     advance;
    logic     res_valid;
    result_t  res;
    logic     out_free;
    result_t  out_res;

    assign in_item.abort     = s_tuser;
    assign in_item.data_byte = s_tdata;

    // The parser consumes a byte only when the result register can take its result.
    assign advance = held_valid && out_free;

    s5rp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .take       (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    s5rp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .item      (held_item),
        .res_valid (res_valid),
        .res       (res)
    );

    s5rp_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && res_valid),
        .load_res  (res),
        .free      (out_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tuser = out_res.kind;
    assign m_tdata = {out_res.port, out_res.name_byte, out_res.domain_length,
                      out_res.ipv4_address, out_res.address_type, out_res.command,
                      out_res.version};

endmodule

`default_nettype wire

>>> tb/socks5_request_parser_test.sv
// Self-checking testbench for the SOCKS5 request parser: a short directed table,
// then mostly well-formed random requests with aborts and noise, checked by a predictor.
// Depends on s5rp_pkg and socks5_request_parser.
`default_nettype none

module socks5_request_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import s5rp_pkg::*;

    localparam int ITEMS      = 950;
    localparam int CALM_ITEMS = 120;
    localparam int LIMIT      = 400000;
    localparam int HOLD_AT    = 300;
    localparam int HOLD_LEN   = 400;
    localparam int IPV4_BYTES = 4;
    localparam logic [7:0] TYPE_IPV6 = 8'd4;
    localparam logic [7:0] SOCKS_VER = 8'd5;

    typedef struct {
        logic       abort;
        logic [7:0] data_byte;
        bit         typed;
        result_t    want;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic [1:0]  m_tuser;

    // Parser state as the predictor sees it.
    phase_t      ph;
    logic [7:0]  cnt;
    logic [7:0]  h_ver;
    logic [7:0]  h_cmd;
    logic [7:0]  h_type;
    logic [31:0] h_addr;
    logic [7:0]  h_len;
    logic [15:0] h_port;

    result_t pending_results[$];
    row_t    plan[$];

    int  errors = 0;
    int  items_sent = 0;
    int  cycles = 0;
    int  rx_gap = 0;
    bit  rx_hold = 1'b0;
    bit  calm = 1'b0;
    int  n_done = 0;
    int  n_names = 0;
    int  n_bad = 0;
    int  n_aborts = 0;

    socks5_request_parser uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #5 aclk = ~aclk;

    task automatic clear_parser();
        ph     = PH_VERSION;
        cnt    = '0;
        h_ver  = '0;
        h_cmd  = '0;
        h_type = '0;
        h_addr = '0;
        h_len  = '0;
        h_port = '0;
    endtask

    function automatic result_t held_result(logic [1:0] kind, logic [31:0] addr,
                                            logic [7:0] len, logic [7:0] name,
                                            logic [15:0] port);
        result_t r;
        r.kind          = kind;
        r.version       = h_ver;
        r.command       = h_cmd;
        r.address_type  = h_type;
        r.ipv4_address  = addr;
        r.domain_length = len;
        r.name_byte     = name;
        r.port          = port;
        return r;
    endfunction

    // Advances the predicted parser by one request byte.
    task automatic parse_byte(input logic ab, input logic [7:0] b,
                              output bit emits, output result_t r);
        emits = 1'b0;
        r = '0;
        if (ab) begin
            clear_parser();
            return;
        end
        case (ph)
            PH_COMMAND: begin
                h_cmd = b;
                ph = PH_RESERVED;
            end
            PH_RESERVED: begin
                ph = PH_TYPE;
            end
            PH_TYPE: begin
                h_type = b;
                h_addr = '0;
                h_len  = '0;
                h_port = '0;
                cnt    = '0;
                if (b == TYPE_IPV4) begin
                    ph = PH_IPV4;
                end else if (b == TYPE_DOMAIN) begin
                    ph = PH_LENGTH;
                end else begin
                    r = held_result(KIND_BAD_TYPE, '0, '0, '0, '0);
                    emits = 1'b1;
                    ph = PH_VERSION;
                end
            end
            PH_IPV4: begin
                h_addr = {h_addr[23:0], b};
                cnt = cnt + 8'd1;
                if (cnt >= IPV4_BYTES) begin
                    cnt = '0;
                    ph = PH_PORT_HI;
                end
            end
            PH_LENGTH: begin
                h_len = b;
                cnt = '0;
                ph = (b == 8'd0) ? PH_PORT_HI : PH_NAME;
            end
            PH_NAME: begin
                r = held_result(KIND_NAME, '0, h_len, b, '0);
                emits = 1'b1;
                cnt = cnt + 8'd1;
                if (cnt >= h_len) begin
                    cnt = '0;
                    ph = PH_PORT_HI;
                end
            end
            PH_PORT_HI: begin
                h_port = {b, 8'h00};
                ph = PH_PORT_LO;
            end
            PH_PORT_LO: begin
                h_port = {h_port[15:8], b};
                r = held_result(KIND_DONE, h_addr, h_len, '0, h_port);
                emits = 1'b1;
                ph = PH_VERSION;
            end
            default: begin
                h_ver  = b;
                h_cmd  = '0;
                h_type = '0;
                h_addr = '0;
                h_len  = '0;
                h_port = '0;
                cnt    = '0;
                ph = PH_COMMAND;
            end
        endcase
    endtask

    function automatic row_t row(logic ab, logic [7:0] b);
        row_t t;
        t.abort = ab;
        t.data_byte = b;
        t.typed = 1'b0;
        t.want = '0;
        return t;
    endfunction

    function automatic row_t typed_row(logic [7:0] b, logic [1:0] kind, logic [7:0] ver,
                                       logic [7:0] cmd, logic [7:0] typ,
                                       logic [31:0] addr, logic [15:0] port);
        row_t t;
        t.abort = 1'b0;
        t.data_byte = b;
        t.typed = 1'b1;
        t.want = '{kind: kind, version: ver, command: cmd, address_type: typ,
                   ipv4_address: addr, domain_length: 8'd0, name_byte: 8'd0,
                   port: port};
        return t;
    endfunction

    // Offers one request byte, waits for the handshake, then records what it should cause.
    task automatic send_byte(input logic ab, input logic [7:0] b,
                             input bit typed, input result_t want);
        bit      emits;
        result_t r;
        if (!calm && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= ab;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (items_sent >= ITEMS - CALM_ITEMS) calm = 1'b1;
        parse_byte(ab, b, emits, r);
        if (ab) n_aborts++;
        if (emits) begin
            if (typed) r = want;
            pending_results = {pending_results, r};
            case (r.kind)
                KIND_NAME: n_names++;
                KIND_DONE: n_done++;
                default:   n_bad++;
            endcase
        end
    endtask

    // One random request, mostly well formed; sometimes cut short by an abort
    // or replaced by stray bytes followed by an abort.
    task automatic send_request();
        logic [7:0] bytes[$];
        logic [7:0] typ;
        int         len;
        int         pick;
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 6)) send_byte(1'b0, 8'($urandom), 1'b0, '0);
            send_byte(1'b1, 8'($urandom), 1'b0, '0);
            return;
        end
        bytes = {bytes, (($urandom_range(0, 4) != 0) ? SOCKS_VER : 8'($urandom))};
        bytes = {bytes, 8'($urandom)};
        bytes = {bytes, 8'($urandom)};
        pick = $urandom_range(0, 19);
        if (pick < 9) begin
            typ = TYPE_IPV4;
        end else if (pick < 18) begin
            typ = TYPE_DOMAIN;
        end else begin
            typ = ($urandom_range(0, 1) == 0) ? TYPE_IPV6 : 8'($urandom);
            if (typ == TYPE_IPV4 || typ == TYPE_DOMAIN) typ = TYPE_IPV6;
        end
        bytes = {bytes, typ};
        if (typ == TYPE_IPV4) begin
            repeat (IPV4_BYTES) bytes = {bytes, 8'($urandom)};
        end else if (typ == TYPE_DOMAIN) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) len = $urandom_range(0, 12);
            else if (pick < 19) len = $urandom_range(13, 40);
            else len = $urandom_range(41, 255);
            bytes = {bytes, 8'(len)};
            repeat (len) bytes = {bytes, 8'($urandom)};
        end
        if (typ == TYPE_IPV4 || typ == TYPE_DOMAIN) begin
            bytes = {bytes, 8'($urandom)};
            bytes = {bytes, 8'($urandom)};
        end
        foreach (bytes[i]) begin
            // The run stops at its byte budget, even in the middle of a request.
            if (items_sent >= ITEMS) return;
            if ($urandom_range(0, 59) == 0) begin
                send_byte(1'b1, 8'($urandom), 1'b0, '0);
                return;
            end
            send_byte(1'b0, bytes[i], 1'b0, '0);
        end
    endtask

    task automatic note_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $realtime, field, got,
                 want);
        errors++;
    endtask

    // Result side: random stall bursts, plus one long hold-off requested elsewhere.
    always @(posedge aclk) begin
        if (rx_hold) begin
            m_tready <= 1'b0;
        end else if (rx_gap > 0 && !calm) begin
            m_tready <= 1'b0;
            rx_gap <= rx_gap - 1;
        end else if (!calm && aresetn && $urandom_range(0, 9) == 0) begin
            m_tready <= 1'b0;
            rx_gap <= $urandom_range(0, 15);
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        wait (items_sent >= HOLD_AT);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_LEN) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("result with none pending, kind", 32'(m_tuser), 32'(0));
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.kind)
                    note_mismatch("kind", 32'(m_tuser), 32'(want.kind));
                if (m_tdata[7:0] !== want.version)
                    note_mismatch("version", 32'(m_tdata[7:0]), 32'(want.version));
                if (m_tdata[15:8] !== want.command)
                    note_mismatch("command", 32'(m_tdata[15:8]), 32'(want.command));
                if (m_tdata[23:16] !== want.address_type)
                    note_mismatch("address_type", 32'(m_tdata[23:16]),
                                  32'(want.address_type));
                if (m_tdata[55:24] !== want.ipv4_address)
                    note_mismatch("ipv4_address", m_tdata[55:24], want.ipv4_address);
                if (m_tdata[63:56] !== want.domain_length)
                    note_mismatch("domain_length", 32'(m_tdata[63:56]),
                                  32'(want.domain_length));
                if (m_tdata[71:64] !== want.name_byte)
                    note_mismatch("name_byte", 32'(m_tdata[71:64]), 32'(want.name_byte));
                if (m_tdata[87:72] !== want.port)
                    note_mismatch("port", 32'(m_tdata[87:72]), 32'(want.port));
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding", cycles,
                     pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        clear_parser();
        // Abort straight after reset, then an IPv4 request with every other field at its top value.
        plan = {plan, row(1'b1, 8'hA5)};
        plan = {plan, row(1'b0, 8'hFF)};
        plan = {plan, row(1'b0, 8'hFF)};
        plan = {plan, row(1'b0, 8'hFF)};
        plan = {plan, row(1'b0, TYPE_IPV4)};
        repeat (5) plan = {plan, row(1'b0, 8'hFF)};
        plan = {plan, typed_row(8'hFF, KIND_DONE, 8'hFF, 8'hFF, TYPE_IPV4, 32'hFFFF_FFFF,
                                16'hFFFF)};
        // A request cut short by an abort.
        plan = {plan, row(1'b0, SOCKS_VER)};
        plan = {plan, row(1'b0, 8'h01)};
        plan = {plan, row(1'b1, 8'h5A)};
        // IPv6 is not supported and is reported as an error.
        plan = {plan, row(1'b0, SOCKS_VER)};
        plan = {plan, row(1'b0, 8'h01)};
        plan = {plan, row(1'b0, 8'h00)};
        plan = {plan, typed_row(TYPE_IPV6, KIND_BAD_TYPE, SOCKS_VER, 8'h01, TYPE_IPV6,
                                32'h0, 16'h0)};
        // Domain request with an empty name and all other bytes zero.
        plan = {plan, row(1'b0, 8'h00)};
        plan = {plan, row(1'b0, 8'h00)};
        plan = {plan, row(1'b0, 8'h00)};
        plan = {plan, row(1'b0, TYPE_DOMAIN)};
        plan = {plan, row(1'b0, 8'h00)};
        plan = {plan, row(1'b0, 8'h00)};
        plan = {plan, typed_row(8'h00, KIND_DONE, 8'h00, 8'h00, TYPE_DOMAIN, 32'h0, 16'h0)};

        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) send_byte(plan[i].abort, plan[i].data_byte, plan[i].typed,
                                    plan[i].want);
        while (items_sent < ITEMS) send_request();
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("%0d request bytes sent: %0d requests completed, %0d name bytes,",
                 items_sent, n_done, n_names);
        $display("%0d unsupported address types and %0d aborts, with stalls on both sides.",
                 n_bad, n_aborts);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
src/s5rp_pkg.sv
src/s5rp_in_stage.sv
src/s5rp_parser.sv
src/s5rp_out_reg.sv
src/socks5_request_parser.sv
tb/socks5_request_parser_test.sv
